/* rtl/sti_pkg.sv */
// Shared types, codes and defaults for the segment-triangle intersection block.
package sti_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	typedef enum logic [2:0] {
		OUT_HIT        = 3'd0,
		OUT_SAME_SIDE  = 3'd1,
		OUT_COPLANAR   = 3'd2,
		OUT_OUTSIDE    = 3'd3,
		OUT_DEGENERATE = 3'd4
	} outcome_t;

	localparam logic [1:0] REG_VERTEX_A = 2'd0;
	localparam logic [1:0] REG_VERTEX_B = 2'd1;
	localparam logic [1:0] REG_VERTEX_C = 2'd2;

	typedef struct packed {
		logic     hit;
		outcome_t outcome;
	} verdict_t;

endpackage

/* rtl/sti_div.sv */
// Pipelined restoring divider that forms the crossing position, one quotient bit per stage.
module sti_div #(
	parameter int W  = 54,
	parameter int QB = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  sti_pkg::verdict_t   in_vd,
	input  logic [W-1:0]        in_num,
	input  logic [W-1:0]        in_den,
	output logic                out_valid,
	output logic                hit,
	output logic [QB-1:0]       t_param,
	output logic [2:0]          outcome
);
	import sti_pkg::*;

	logic           v_s   [QB+1];
	verdict_t       vd_s  [QB+1];
	logic [W-1:0]   num_s [QB+1];
	logic [W-1:0]   den_s [QB+1];
	logic [QB-1:0]  q_s   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QB; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_v;
			for (int j = 0; j < QB; j++) begin
				v_s[j+1] <= v_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vd_s[0]  <= in_vd;
			num_s[0] <= in_num;
			den_s[0] <= in_den;
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic         ge;
		logic [W-1:0] rem;
		assign ge  = num_s[j] >= den_s[j];
		assign rem = ge ? num_s[j] - den_s[j] : num_s[j];
		always_ff @(posedge clk) begin
			if (en) begin
				vd_s[j+1]  <= vd_s[j];
				den_s[j+1] <= den_s[j];
				num_s[j+1] <= {rem[W-2:0], 1'b0};
				q_s[j+1]   <= {q_s[j][QB-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[QB];
	assign hit       = vd_s[QB].hit;
	assign outcome   = vd_s[QB].outcome;
	assign t_param   = vd_s[QB].hit ? q_s[QB] : '0;

endmodule

/* rtl/segment_triangle_intersect.sv */
// Top level of the segment-triangle intersection pipeline.
// Usage: load the three triangle vertices through the write port (cfg_we,
// cfg_index, cfg_data) while no word is in flight, then stream segments.
// Each input word carries the segment start and end points; it is taken
// at a clock edge where in_valid is high and in_stall is low. Each output
// word carries hit, t_param and outcome and is taken at an edge where
// out_valid is high and out_stall is low.
// From input to output a word passes four stages of differences, products
// and sums, the divider's input register, then one divider stage per
// quotient bit, the last of which is the output register.
// A new word enters every cycle unless the output stalls, or in the cycle
// right after a register write, when in_stall is high while the normal settles.
// When the receiver stalls a valid output word, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and the vertex registers to zero.
module segment_triangle_intersect #(
	parameter int COORD_BITS  = sti_pkg::COORD_BITS_DEF,
	parameter int T_FRAC_BITS = sti_pkg::T_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [3*COORD_BITS-1:0]       cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  start_z,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic signed [COORD_BITS-1:0]  end_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [T_FRAC_BITS:0]          t_param,
	output logic [2:0]                    outcome
);
	import sti_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int NW = 2 * C + 3;
	localparam int PW = D + NW;
	localparam int DW = 3 * C + 6;
	localparam int RW = 3 * C;

	logic en;
	logic cfg_hold_q;

	logic [RW-1:0] va_q, vb_q, vc_q;
	logic signed [C-1:0] vtx [3][3];
	logic signed [C-1:0] st [3];
	logic signed [C-1:0] ed [3];
	logic signed [D-1:0] ab [3];
	logic signed [D-1:0] ac [3];
	logic signed [2*D-1:0] np_q [6];
	logic signed [NW-1:0] n_q [3];
	logic deg;
	logic [1:0] ax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_A: va_q <= cfg_data;
				REG_VERTEX_B: vb_q <= cfg_data;
				REG_VERTEX_C: vc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_we;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign vtx[0][i] = va_q[i*C +: C];
		assign vtx[1][i] = vb_q[i*C +: C];
		assign vtx[2][i] = vc_q[i*C +: C];
		assign ab[i] = D'(vtx[1][i]) - D'(vtx[0][i]);
		assign ac[i] = D'(vtx[2][i]) - D'(vtx[0][i]);
	end

	assign st = '{start_x, start_y, start_z};
	assign ed = '{end_x, end_y, end_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				np_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= '0;
			end
		end else begin
			np_q[0] <= (2*D)'(ab[1]) * (2*D)'(ac[2]);
			np_q[1] <= (2*D)'(ab[2]) * (2*D)'(ac[1]);
			np_q[2] <= (2*D)'(ab[2]) * (2*D)'(ac[0]);
			np_q[3] <= (2*D)'(ab[0]) * (2*D)'(ac[2]);
			np_q[4] <= (2*D)'(ab[0]) * (2*D)'(ac[1]);
			np_q[5] <= (2*D)'(ab[1]) * (2*D)'(ac[0]);
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= NW'(np_q[2*i]) - NW'(np_q[2*i+1]);
			end
		end
	end

	assign deg = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
	assign ax  = (n_q[0] != '0) ? 2'd0 : ((n_q[1] != '0) ? 2'd1 : 2'd2);

	// Stage 1: differences from the segment and triangle points.
	logic v_s1, same_s1;
	logic signed [D-1:0] t0_s1 [3];
	logic signed [D-1:0] t1_s1 [3];
	logic signed [D-1:0] dir_s1 [3];
	logic signed [D-1:0] xs_s1 [3][3];

	// Stage 2: products.
	logic v_s2, same_s2;
	logic signed [PW-1:0] dp_s2 [2][3];
	logic signed [2*D-1:0] cp_s2 [3][6];
	logic signed [D-1:0] dir_s2 [3];

	// Stage 3: plane distances and edge cross products.
	logic v_s3, same_s3;
	logic signed [DW-1:0] d_s3 [2];
	logic signed [NW-1:0] cr_s3 [3][3];
	logic signed [D-1:0] dir_s3 [3];

	// Stage 4: edge products, signs and magnitudes.
	logic v_s4, same_s4;
	logic signed [PW-1:0] ep_s4 [3][3];
	logic ppos_s4, pneg_s4;
	logic d0neg_s4, d0zero_s4, d1neg_s4, d1zero_s4;
	logic [DW-1:0] a0_s4, a1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && !cfg_hold_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			same_s1 <= (start_x == end_x) && (start_y == end_y) && (start_z == end_z);
			for (int i = 0; i < 3; i++) begin
				t0_s1[i]  <= D'(st[i]) - D'(vtx[0][i]);
				t1_s1[i]  <= D'(ed[i]) - D'(vtx[0][i]);
				dir_s1[i] <= D'(ed[i]) - D'(st[i]);
				for (int e = 0; e < 3; e++) begin
					xs_s1[e][i] <= D'(vtx[e][i]) - D'(st[i]);
				end
			end

			same_s2 <= same_s1;
			dir_s2  <= dir_s1;
			for (int i = 0; i < 3; i++) begin
				dp_s2[0][i] <= PW'(t0_s1[i]) * PW'(n_q[i]);
				dp_s2[1][i] <= PW'(t1_s1[i]) * PW'(n_q[i]);
			end
			for (int e = 0; e < 3; e++) begin
				cp_s2[e][0] <= (2*D)'(xs_s1[e][1]) * (2*D)'(xs_s1[(e+1)%3][2]);
				cp_s2[e][1] <= (2*D)'(xs_s1[e][2]) * (2*D)'(xs_s1[(e+1)%3][1]);
				cp_s2[e][2] <= (2*D)'(xs_s1[e][2]) * (2*D)'(xs_s1[(e+1)%3][0]);
				cp_s2[e][3] <= (2*D)'(xs_s1[e][0]) * (2*D)'(xs_s1[(e+1)%3][2]);
				cp_s2[e][4] <= (2*D)'(xs_s1[e][0]) * (2*D)'(xs_s1[(e+1)%3][1]);
				cp_s2[e][5] <= (2*D)'(xs_s1[e][1]) * (2*D)'(xs_s1[(e+1)%3][0]);
			end

			same_s3 <= same_s2;
			dir_s3  <= dir_s2;
			for (int k = 0; k < 2; k++) begin
				d_s3[k] <= DW'(dp_s2[k][0]) + DW'(dp_s2[k][1]) + DW'(dp_s2[k][2]);
			end
			for (int e = 0; e < 3; e++) begin
				for (int i = 0; i < 3; i++) begin
					cr_s3[e][i] <= NW'(cp_s2[e][2*i]) - NW'(cp_s2[e][2*i+1]);
				end
			end

			same_s4   <= same_s3;
			d0neg_s4  <= d_s3[0][DW-1];
			d1neg_s4  <= d_s3[1][DW-1];
			d0zero_s4 <= d_s3[0] == '0;
			d1zero_s4 <= d_s3[1] == '0;
			a0_s4     <= d_s3[0][DW-1] ? $unsigned(-d_s3[0]) : $unsigned(d_s3[0]);
			a1_s4     <= d_s3[1][DW-1] ? $unsigned(-d_s3[1]) : $unsigned(d_s3[1]);
			ppos_s4   <= 1'b0;
			pneg_s4   <= 1'b0;
			for (int e = 0; e < 3; e++) begin
				if (cr_s3[e][ax] > 0) begin
					ppos_s4 <= 1'b1;
				end
				if (cr_s3[e][ax] < 0) begin
					pneg_s4 <= 1'b1;
				end
				for (int i = 0; i < 3; i++) begin
					ep_s4[e][i] <= PW'(dir_s3[i]) * PW'(cr_s3[e][i]);
				end
			end
		end
	end

	// Stage 5 logic feeds the divider's first register.
	logic signed [DW-1:0] eds [3];
	logic epos, eneg;
	verdict_t vd;
	logic [DW-1:0] den;

	always_comb begin
		epos = 1'b0;
		eneg = 1'b0;
		for (int e = 0; e < 3; e++) begin
			eds[e] = DW'(ep_s4[e][0]) + DW'(ep_s4[e][1]) + DW'(ep_s4[e][2]);
			if (eds[e] > 0) begin
				epos = 1'b1;
			end
			if (eds[e] < 0) begin
				eneg = 1'b1;
			end
		end
		vd.hit     = 1'b0;
		vd.outcome = OUT_HIT;
		if (deg) begin
			vd.outcome = OUT_DEGENERATE;
		end else if (same_s4) begin
			if (!d0zero_s4) begin
				vd.outcome = OUT_SAME_SIDE;
			end else if (ppos_s4 && pneg_s4) begin
				vd.outcome = OUT_OUTSIDE;
			end else begin
				vd.hit = 1'b1;
			end
		end else if ((!d0neg_s4 && !d0zero_s4 && !d1neg_s4 && !d1zero_s4) ||
				(d0neg_s4 && d1neg_s4)) begin
			vd.outcome = OUT_SAME_SIDE;
		end else if (d0zero_s4 && d1zero_s4) begin
			vd.outcome = OUT_COPLANAR;
		end else if (epos && eneg) begin
			vd.outcome = OUT_OUTSIDE;
		end else begin
			vd.hit = 1'b1;
		end
	end

	// A point tested in place hits only with a zero numerator; a unit divisor makes its position zero.
	assign den = same_s4 ? DW'(1) : a0_s4 + a1_s4;

	sti_div #(
		.W (DW),
		.QB(T_FRAC_BITS + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.in_vd    (vd),
		.in_num   (a0_s4),
		.in_den   (den),
		.out_valid(out_valid),
		.hit      (hit),
		.t_param  (t_param),
		.outcome  (outcome)
	);

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en || cfg_hold_q;

endmodule
